// ===== hdl/ycc2rgb_pkg.sv =====
// shared types and constants for the ycbcr to rgb pixel packer
`timescale 1ns / 1ps

package ycc2rgb_pkg;

  localparam logic [1:0] ORDER_BGRA = 2'd0;
  localparam logic [1:0] ORDER_RGBA = 2'd1;
  localparam logic [1:0] ORDER_BGR  = 2'd2;
  localparam logic [1:0] ORDER_RGB  = 2'd3;

  localparam logic signed [15:0] LUMA_OFFSET = 16'sd128;
  localparam logic [7:0]         ALPHA_BYTE  = 8'hFF;
  localparam logic [7:0]         BYTE_MAX    = 8'd255;

  localparam logic [1:0] IDX_ALPHA = 2'd3;
  localparam logic [1:0] IDX_THIRD = 2'd2;

  typedef struct packed {
    logic signed [15:0] luma;
    logic signed [15:0] chroma_blue;
    logic signed [15:0] chroma_red;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_of_pixel;
  } byte_out_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       four;
  } pix_word_t;

  function automatic logic [7:0] clamp8(input logic signed [15:0] v);
    logic [7:0] res;
    if (v < 16'sd0) begin
      res = 8'd0;
    end else if (v > 16'sd255) begin
      res = BYTE_MAX;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/ycc2rgb_front.sv =====
// front part: accepts pixels, converts to clamped rgb and orders the bytes
`timescale 1ns / 1ps

module ycc2rgb_front
  import ycc2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic [1:0] pixel_order,
  input  logic      in_valid,
  output logic      in_ready,
  input  pix_in_t   in_data,
  output logic      word_valid,
  input  logic      word_ready,
  output pix_word_t word_data
);

  logic signed [15:0] y;
  logic signed [15:0] cb;
  logic signed [15:0] cr;
  logic signed [15:0] r_sum;
  logic signed [15:0] g_sum;
  logic signed [15:0] b_sum;
  logic [7:0]         r_byte;
  logic [7:0]         g_byte;
  logic [7:0]         b_byte;
  logic               blue_first;
  pix_word_t          word_next;

  assign y  = in_data.luma + LUMA_OFFSET;
  assign cb = in_data.chroma_blue;
  assign cr = in_data.chroma_red;

  assign r_sum = y + cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
  assign g_sum = y - ((cb >>> 2) + (cb >>> 4) + (cb >>> 5))
                   - ((cr >>> 1) + (cr >>> 3) + (cr >>> 4) + (cr >>> 5));
  assign b_sum = y + cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);

  assign r_byte = clamp8(r_sum);
  assign g_byte = clamp8(g_sum);
  assign b_byte = clamp8(b_sum);

  assign blue_first = (pixel_order == ORDER_BGRA) || (pixel_order == ORDER_BGR);

  always_comb begin
    word_next.byte0 = blue_first ? b_byte : r_byte;
    word_next.byte1 = g_byte;
    word_next.byte2 = blue_first ? r_byte : b_byte;
    word_next.four  = (pixel_order == ORDER_BGRA) || (pixel_order == ORDER_RGBA);
  end

  assign in_ready = !word_valid || word_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_data <= word_next;
    end
  end

endmodule

// ===== hdl/ycc2rgb_queue.sv =====
// two-entry queue of converted pixels between front and back
`timescale 1ns / 1ps

module ycc2rgb_queue
  import ycc2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  pix_word_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output pix_word_t rd_data
);

  pix_word_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/ycc2rgb_back.sv =====
// back part: sends each converted pixel as a run of bytes
`timescale 1ns / 1ps

module ycc2rgb_back
  import ycc2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      word_valid,
  output logic      word_ready,
  input  pix_word_t word_data,
  output logic      out_valid,
  input  logic      out_ready,
  output byte_out_t out_data
);

  pix_word_t  cur;
  logic       busy;
  logic [1:0] idx;
  logic       last;
  logic       take;

  assign last = cur.four ? (idx == IDX_ALPHA) : (idx == IDX_THIRD);
  assign word_ready = !busy || (out_ready && last);
  assign take = word_valid && word_ready;
  assign out_valid = busy;

  always_comb begin
    case (idx)
      2'd0:    out_data.pixel_byte = cur.byte0;
      2'd1:    out_data.pixel_byte = cur.byte1;
      2'd2:    out_data.pixel_byte = cur.byte2;
      default: out_data.pixel_byte = ALPHA_BYTE;
    endcase
    out_data.last_of_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= word_data;
    end
  end

endmodule

// ===== hdl/ycbcr_to_rgb_pixel_packer_top.sv =====
// top level of the ycbcr to rgb pixel packer
//
// input channel: in_valid / in_ready / in_data carry one pixel item of
// signed luma, blue chroma and red chroma samples.
// output channel: out_valid / out_ready / out_data carry one byte item
// with last_of_pixel set on the final byte of each pixel.
// cfg_we / cfg_wdata write pixel_order (0 bgra, 1 rgba, 2 bgr, 3 rgb);
// write it only while no pixel is in flight.
// when the block is empty, an accepted pixel passes the conversion
// register, then the queue and the byte serializer, before its first
// byte appears on the output channel.
// the one-byte output channel sets the pace: each pixel leaves as four
// bytes for four-byte orders and as three bytes for three-byte orders.
// a two-entry queue sits between converter and serializer, so up to four
// pixels can be held while the receiver stalls; in_ready drops once all
// are full and no byte is lost or repeated.
// reset: rst is synchronous; it empties the pipeline and sets pixel_order
// to bgra.
`timescale 1ns / 1ps

module ycbcr_to_rgb_pixel_packer_top
  import ycc2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  pix_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output byte_out_t out_data
);

  logic [1:0] pixel_order;
  logic       f_valid;
  logic       f_ready;
  pix_word_t  f_data;
  logic       q_valid;
  logic       q_ready;
  pix_word_t  q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_order <= ORDER_BGRA;
    end else if (cfg_we) begin
      pixel_order <= cfg_wdata;
    end
  end

  ycc2rgb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_order (pixel_order),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .word_valid  (f_valid),
    .word_ready  (f_ready),
    .word_data   (f_data)
  );

  ycc2rgb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  ycc2rgb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .word_valid (q_valid),
    .word_ready (q_ready),
    .word_data  (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
